/* sv/tcw_pkg.sv */
// Package for the text console writer: field widths, command and character codes,
// and the command and status types between controller and datapath.
// Depends on nothing; every other file of the block but tcw_ram imports it.
package tcw_pkg;

    localparam int CMD_W       = 3;
    localparam int CHAR_W      = 8;
    localparam int PORT_ADDR_W = 11;
    localparam int CELL_W      = 16;
    localparam int COLOR_W     = 4;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_CHAR = 3'd0,
        CMD_UP         = 3'd1,
        CMD_DOWN       = 3'd2,
        CMD_LEFT       = 3'd3,
        CMD_RIGHT      = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_READ       = 3'd6,
        CMD_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FG_COLOR = 1'b0,
        CFG_BG_COLOR = 1'b1
    } cfg_index_t;

    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE      = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB            = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE        = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN         = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_BLANK          = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST_PRINTABLE = 8'h7F;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0020;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EXEC,
        OP_INIT,
        OP_CLEAR,
        OP_SCROLL,
        OP_BLANK,
        OP_READ_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        PTR_KEEP,
        PTR_FIRST_CELL,
        PTR_SECOND_ROW,
        PTR_LAST_ROW
    } ptr_load_t;

    typedef struct packed {
        dp_op_t    op;
        ptr_load_t ptr_load;
        logic      out_load;
    } dp_ctrl_t;

    typedef struct packed {
        logic out_busy;
        logic sweep_done;
        logic need_scroll;
        logic is_clear;
        logic is_read;
    } dp_status_t;

endpackage

/* sv/tcw_item_if.sv */
// Input channel of the text console writer: valid, ready and one command item.
// Depends on tcw_pkg for the field widths.
interface tcw_item_if;
    import tcw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [CHAR_W-1:0]      char_code;
    logic [PORT_ADDR_W-1:0] read_address;

    modport source (output valid, cmd, char_code, read_address, input ready);
    modport sink (input valid, cmd, char_code, read_address, output ready);
endinterface

/* sv/tcw_result_if.sv */
// Result channel of the text console writer: valid, ready and one result item.
// Depends on tcw_pkg for the field widths.
interface tcw_result_if;
    import tcw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PORT_ADDR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]      read_data;

    modport source (output valid, cursor_pos, read_data, input ready);
    modport sink (input valid, cursor_pos, read_data, output ready);
endinterface

/* sv/tcw_ram.sv */
// Generic RAM with one write port and one read port with registered read data.
// Depends on nothing.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* sv/tcw_ctrl.sv */
// Controller of the text console writer: sequences item execution, memory sweeps
// and result loading. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_ctrl_t   ctrl
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_BLANK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        ctrl.op       = OP_NONE;
        ctrl.ptr_load = PTR_KEEP;
        ctrl.out_load = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ctrl.op = OP_INIT;
                if (status.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = !status.out_busy;
                if (item_valid && !status.out_busy)
                begin
                    ctrl.op = OP_EXEC;
                    if (status.need_scroll)
                    begin
                        ctrl.ptr_load = PTR_SECOND_ROW;
                        state_next    = S_SCROLL;
                    end
                    else if (status.is_clear)
                    begin
                        ctrl.ptr_load = PTR_FIRST_CELL;
                        state_next    = S_CLEAR;
                    end
                    else if (status.is_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        ctrl.out_load = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                ctrl.op       = OP_READ_OUT;
                ctrl.out_load = 1'b1;
                state_next    = S_IDLE;
            end
            S_CLEAR:
            begin
                ctrl.op = OP_CLEAR;
                if (status.sweep_done)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCROLL:
            begin
                ctrl.op = OP_SCROLL;
                if (status.sweep_done)
                begin
                    ctrl.ptr_load = PTR_LAST_ROW;
                    state_next    = S_BLANK;
                end
            end
            S_BLANK:
            begin
                ctrl.op = OP_BLANK;
                if (status.sweep_done)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && status.is_read) |=> ctrl.out_load)
        else $error("Read transaction did not load its result in the next cycle.");

    a_scroll_then_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL && status.sweep_done) |=> state_reg == S_BLANK)
        else $error("Scroll copy did not continue with blanking the last row.");

    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !item_ready)
        else $error("Transaction accepted during the initial fill.");
endmodule

/* sv/tcw_dp.sv */
// Datapath of the text console writer: cursor, colors, cell store, sweep pointer
// and result register. Depends on tcw_pkg and tcw_ram.
module tcw_dp #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]          cfg_data,
    input  logic [tcw_pkg::CMD_W-1:0]            item_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]           item_char,
    input  logic [tcw_pkg::PORT_ADDR_W-1:0]      item_read_address,
    input  logic                                 result_ready,
    output logic                                 result_valid,
    output logic [tcw_pkg::PORT_ADDR_W-1:0]      cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]           read_data,
    input  tcw_pkg::dp_ctrl_t                    ctrl,
    output tcw_pkg::dp_status_t                  status
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int NCW   = $clog2(COLUMNS + TAB_WIDTH);
    localparam int NRW   = $clog2(ROWS + 1);

    logic [COLOR_W-1:0]     fg_reg, fg_next;
    logic [COLOR_W-1:0]     bg_reg, bg_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [PW-1:0]          ptr_reg, ptr_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PORT_ADDR_W-1:0] out_cursor_reg, out_cursor_next;
    logic [CELL_W-1:0]      out_data_reg, out_data_next;

    logic [NCW-1:0]         tab_stop [COLUMNS];
    cmd_t                   cmd;
    logic                   printable;
    logic [NCW-1:0]         col_step;
    logic [NRW-1:0]         row_step;
    logic [CW-1:0]          col_new;
    logic [RW-1:0]          row_new;
    logic                   need_scroll;
    logic                   char_write;
    logic                   bs_write;
    logic [AW-1:0]          idx_cur;
    logic [AW-1:0]          idx_new;
    logic [CELL_W-1:0]      blank;
    logic                   sweep_done;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [CELL_W-1:0]      ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [CELL_W-1:0]      ram_rdata;

    for (genvar i = 0; i < COLUMNS; i++)
    begin : g_tab
        assign tab_stop[i] = NCW'(((i / TAB_WIDTH) + 1) * TAB_WIDTH);
    end

    assign cmd       = cmd_t'(item_cmd);
    assign printable = (item_char >= CHAR_BLANK) && (item_char <= CHAR_LAST_PRINTABLE);
    assign blank     = {bg_reg, fg_reg, CHAR_BLANK};

    always_comb
    begin
        col_step   = NCW'(col_reg);
        row_step   = NRW'(row_reg);
        char_write = 1'b0;
        bs_write   = 1'b0;
        case (cmd)
            CMD_WRITE_CHAR:
            begin
                if (item_char == CHAR_NEWLINE)
                begin
                    col_step = '0;
                    row_step = NRW'(row_reg) + 1'b1;
                end
                else if (item_char == CHAR_RETURN)
                begin
                    col_step = '0;
                end
                else if (item_char == CHAR_BACKSPACE)
                begin
                    if (col_reg != '0)
                    begin
                        col_step = NCW'(col_reg) - 1'b1;
                        bs_write = 1'b1;
                    end
                end
                else if (item_char == CHAR_TAB)
                begin
                    col_step = tab_stop[col_reg];
                end
                else if (printable)
                begin
                    col_step   = NCW'(col_reg) + 1'b1;
                    char_write = 1'b1;
                end
                if (col_step >= NCW'(COLUMNS))
                begin
                    col_step = '0;
                    row_step = row_step + 1'b1;
                end
            end
            CMD_UP:
            begin
                if (row_reg != '0)
                begin
                    row_step = NRW'(row_reg) - 1'b1;
                end
            end
            CMD_DOWN:
            begin
                if (row_reg != RW'(ROWS - 1))
                begin
                    row_step = NRW'(row_reg) + 1'b1;
                end
            end
            CMD_LEFT:
            begin
                if (col_reg != '0)
                begin
                    col_step = NCW'(col_reg) - 1'b1;
                end
            end
            CMD_RIGHT:
            begin
                if (col_reg != CW'(COLUMNS - 1))
                begin
                    col_step = NCW'(col_reg) + 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                col_step = '0;
                row_step = '0;
            end
            default:
            begin
            end
        endcase
        need_scroll = row_step >= NRW'(ROWS);
        col_new     = need_scroll ? '0 : col_step[CW-1:0];
        row_new     = need_scroll ? RW'(ROWS - 1) : row_step[RW-1:0];
    end

    assign idx_cur = AW'(row_reg * COLUMNS) + AW'(col_reg);
    assign idx_new = AW'(row_new * COLUMNS) + AW'(col_new);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg[AW-1:0];
        ram_wdata = blank;
        case (ctrl.op)
            OP_EXEC:
            begin
                if (char_write)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_cur;
                    ram_wdata = {bg_reg, fg_reg, item_char};
                end
                else if (bs_write)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_cur - 1'b1;
                end
            end
            OP_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
            end
            OP_CLEAR, OP_BLANK:
            begin
                ram_we = 1'b1;
            end
            OP_SCROLL:
            begin
                ram_we    = ptr_reg > PW'(COLUMNS);
                ram_waddr = AW'(ptr_reg - PW'(COLUMNS) - 1'b1);
                ram_wdata = ram_rdata;
            end
            default:
            begin
            end
        endcase
    end

    assign ram_raddr = (ctrl.op == OP_SCROLL) ? ptr_reg[AW-1:0] : AW'(item_read_address);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        ptr_next        = ptr_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg;
        out_cursor_next = out_cursor_reg;
        out_data_next   = out_data_reg;

        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FG_COLOR: fg_next = cfg_data;
                CFG_BG_COLOR: bg_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (ctrl.op == OP_EXEC)
        begin
            col_next   = col_new;
            row_next   = row_new;
            rd_ok_next = int'(item_read_address) < CELLS;
        end

        case (ctrl.ptr_load)
            PTR_FIRST_CELL: ptr_next = '0;
            PTR_SECOND_ROW: ptr_next = PW'(COLUMNS);
            PTR_LAST_ROW:   ptr_next = PW'(CELLS - COLUMNS);
            default:
            begin
                if (ctrl.op == OP_INIT || ctrl.op == OP_CLEAR ||
                    ctrl.op == OP_SCROLL || ctrl.op == OP_BLANK)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
        endcase

        if (ctrl.out_load)
        begin
            out_valid_next  = 1'b1;
            out_cursor_next = (ctrl.op == OP_EXEC) ? PORT_ADDR_W'(idx_new)
                                                   : PORT_ADDR_W'(idx_cur);
            out_data_next   = (ctrl.op == OP_READ_OUT && rd_ok_reg) ? ram_rdata : '0;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        case (ctrl.op)
            OP_SCROLL:                   sweep_done = ptr_reg == PW'(CELLS);
            OP_INIT, OP_CLEAR, OP_BLANK: sweep_done = ptr_reg == PW'(CELLS - 1);
            default:                     sweep_done = 1'b0;
        endcase
    end

    assign status.sweep_done  = sweep_done;
    assign status.out_busy    = out_valid_reg && !result_ready;
    assign status.need_scroll = need_scroll;
    assign status.is_clear    = cmd == CMD_CLEAR;
    assign status.is_read     = cmd == CMD_READ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg        <= '0;
            bg_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            ptr_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ptr_reg       <= ptr_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cursor_reg <= out_cursor_next;
        out_data_reg   <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign cursor_pos   = out_cursor_reg;
    assign read_data    = out_data_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS))
        else $error("Cursor left the screen.");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> !status.out_busy)
        else $error("Result register loaded while a result was still pending.");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EXEC && status.need_scroll) |=>
        (row_reg == RW'(ROWS - 1)) && (col_reg == '0))
        else $error("Cursor not at the start of the last row after a scroll.");
endmodule

/* sv/text_console_writer.sv */
// Text console writer: a character screen store with cursor, printing and scrolling.
// For cursor moves and characters that do not scroll, a result appears in the cycle
// after its transaction; a cell read passes through the read state first. A clear
// and a scroll each sweep the cell store through its single write port, one cell
// per cycle. After reset a clearing pass fills the store with blanks and no
// transaction is accepted meanwhile; configuration writes are taken at any time.
// The next transaction is accepted once the block is idle and the result register
// is empty or being emptied.
module text_console_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data,
    tcw_item_if.sink                        item,
    tcw_result_if.source                    result
);
    import tcw_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .ctrl       (ctrl)
    );

    tcw_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_cmd          (item.cmd),
        .item_char         (item.char_code),
        .item_read_address (item.read_address),
        .result_ready      (result.ready),
        .result_valid      (result.valid),
        .cursor_pos        (result.cursor_pos),
        .read_data         (result.read_data),
        .ctrl              (ctrl),
        .status            (status)
    );
endmodule
